// File: rtl/rn_pkg.sv
`default_nettype none
package rn_pkg;

  // widths fixed by the item fields
  localparam int NUM_W    = 12;
  localparam int LETTER_W = 7;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // largest number with a standard numeral
  localparam logic [NUM_W-1:0] MAX_VALID = 12'd3999;

  // reciprocal multipliers for the constant divisions
  localparam logic [12:0] RECIP_100 = 13'd5243;  // /100 as *5243 >> 19
  localparam logic [12:0] RECIP_10  = 13'd6554;  // /10  as *6554 >> 16

  // ascii codes of the numeral letters
  localparam logic [LETTER_W-1:0] CH_I = 7'h49;
  localparam logic [LETTER_W-1:0] CH_V = 7'h56;
  localparam logic [LETTER_W-1:0] CH_X = 7'h58;
  localparam logic [LETTER_W-1:0] CH_L = 7'h4C;
  localparam logic [LETTER_W-1:0] CH_C = 7'h43;
  localparam logic [LETTER_W-1:0] CH_D = 7'h44;
  localparam logic [LETTER_W-1:0] CH_M = 7'h4D;

  // digit places, most significant first
  localparam logic [1:0] POS_TH = 2'd0;
  localparam logic [1:0] POS_HU = 2'd1;
  localparam logic [1:0] POS_TE = 2'd2;
  localparam logic [1:0] POS_ON = 2'd3;

  // role of a letter within one digit's pattern
  typedef enum logic [1:0] {
    SYM_ONE,
    SYM_FIVE,
    SYM_TEN
  } sym_t;

  // classified item passed from front to back
  typedef struct packed {
    logic       err;
    logic [1:0] th;
    logic [3:0] hu;
    logic [3:0] te;
    logic [3:0] on;
  } item_t;

  // number of letters a decimal digit produces
  function automatic logic [2:0] dig_len(input logic [3:0] d);
    logic [2:0] len;
    unique case (d)
      4'd1:    len = 3'd1;
      4'd2:    len = 3'd2;
      4'd3:    len = 3'd3;
      4'd4:    len = 3'd2;
      4'd5:    len = 3'd1;
      4'd6:    len = 3'd2;
      4'd7:    len = 3'd3;
      4'd8:    len = 3'd4;
      4'd9:    len = 3'd2;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // letter role at a given place within a digit's pattern
  function automatic sym_t dig_sym(input logic [3:0] d, input logic [1:0] idx);
    sym_t s;
    if (d == 4'd9) begin
      s = (idx == 2'd0) ? SYM_ONE : SYM_TEN;
    end else if (d == 4'd4) begin
      s = (idx == 2'd0) ? SYM_ONE : SYM_FIVE;
    end else if (d >= 4'd5 && idx == 2'd0) begin
      s = SYM_FIVE;
    end else begin
      s = SYM_ONE;
    end
    return s;
  endfunction

  // ascii letter for a role at a digit place
  function automatic logic [LETTER_W-1:0] roman_letter(input logic [1:0] pos,
                                                       input sym_t sym);
    logic [LETTER_W-1:0] one, five, ten, ch;
    unique case (pos)
      POS_TH:  begin one = CH_M; five = CH_M; ten = CH_M; end
      POS_HU:  begin one = CH_C; five = CH_D; ten = CH_M; end
      POS_TE:  begin one = CH_X; five = CH_L; ten = CH_C; end
      default: begin one = CH_I; five = CH_V; ten = CH_X; end
    endcase
    unique case (sym)
      SYM_FIVE: ch = five;
      SYM_TEN:  ch = ten;
      default:  ch = one;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

// File: rtl/decimal_to_roman_numeral.sv
`default_nettype none
// channel | ports                                       | direction
// --------+---------------------------------------------+----------
// input   | in_valid, in_ready, in_number               | in
// result  | out_valid, out_ready, out_letter,           | out
//         | out_last_letter, out_out_of_range           |
//
// one letter per cycle leaves the back end unless out_ready holds it back; a
// numeral has 1 to 15 letters, and an out-of-range number gives a single one.
// a number moves through stages a and b, the queue and the output register.
// the front splits digits in a two-stage pipeline and feeds a small queue, so
// input keeps flowing while the back end is held by out_ready, until the queue
// and both front stages are full.
// synchronous active-low reset empties the pipeline, queue and output register.
module decimal_to_roman_numeral #(
  parameter int QueueDepth = rn_pkg::QUEUE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [rn_pkg::NUM_W-1:0]      in_number,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [rn_pkg::LETTER_W-1:0]        out_letter,
  output logic                               out_last_letter,
  output logic                               out_out_of_range
);
  import rn_pkg::*;

  logic  push, q_full, pop, not_empty;
  item_t push_item, head;

  // range check and digit split
  rn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_number (in_number),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  // decoupling queue
  rn_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  // letter sequencer
  rn_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .not_empty        (not_empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_letter       (out_letter),
    .out_last_letter  (out_last_letter),
    .out_out_of_range (out_out_of_range)
  );

endmodule
`default_nettype wire

// File: rtl/rn_front.sv
`default_nettype none
module rn_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [rn_pkg::NUM_W-1:0] in_number,
  output logic                        push,
  output rn_pkg::item_t               push_item,
  input  wire logic                   q_full
);
  import rn_pkg::*;

  // stage a: accepted number
  logic             a_v_r;
  logic [NUM_W-1:0] num_a_r;

  // stage b: quotients by 100 and by 10
  logic             b_v_r;
  logic             b_err_r;
  logic [5:0]       q100_r;
  logic [8:0]       q10_r;
  logic [NUM_W-1:0] num_b_r;

  logic             a_adv, b_adv;
  logic [24:0]      prod100, prod10;
  logic             err_a;
  logic [1:0]       th;
  logic [5:0]       th_ten;
  logic [8:0]       q100_ten;
  logic [NUM_W-1:0] q10_ten;

  // stall chain back from the queue
  assign push     = b_v_r && !q_full;
  assign b_adv    = !b_v_r || push;
  assign a_adv    = !a_v_r || b_adv;
  assign in_ready = a_adv;

  // range check and reciprocal quotients
  assign prod100 = 25'(num_a_r) * 25'(RECIP_100);
  assign prod10  = 25'(num_a_r) * 25'(RECIP_10);
  assign err_a   = (num_a_r == '0) || (num_a_r > MAX_VALID);

  // digits from the quotients
  always_comb begin
    priority if (q100_r >= 6'd30) th = 2'd3;
    else if (q100_r >= 6'd20)     th = 2'd2;
    else if (q100_r >= 6'd10)     th = 2'd1;
    else                          th = 2'd0;
  end

  assign th_ten   = 6'(th) * 6'd10;
  assign q100_ten = 9'(q100_r) * 9'd10;
  assign q10_ten  = 12'(q10_r) * 12'd10;

  assign push_item.err = b_err_r;
  assign push_item.th  = th;
  assign push_item.hu  = 4'(q100_r - th_ten);
  assign push_item.te  = 4'(q10_r - q100_ten);
  assign push_item.on  = 4'(num_b_r - q10_ten);

  // stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (a_adv) a_v_r <= in_valid;
      if (b_adv) b_v_r <= a_v_r;
    end
    if (a_adv && in_valid) num_a_r <= in_number;
    if (b_adv && a_v_r) begin
      b_err_r <= err_a;
      q100_r  <= prod100[24:19];
      q10_r   <= prod10[24:16];
      num_b_r <= num_a_r;
    end
  end

endmodule
`default_nettype wire

// File: rtl/rn_queue.sv
`default_nettype none
module rn_queue #(
  parameter int Depth = rn_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  rn_pkg::item_t      push_item,
  output logic               full,
  input  wire logic          pop,
  output rn_pkg::item_t      head,
  output logic               not_empty
);
  import rn_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  item_t           mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;

  assign full      = (count_r == CntW'(Depth));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule
`default_nettype wire

// File: rtl/rn_back.sv
`default_nettype none
module rn_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  rn_pkg::item_t                    head,
  input  wire logic                        not_empty,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [rn_pkg::LETTER_W-1:0]      out_letter,
  output logic                             out_last_letter,
  output logic                             out_out_of_range
);
  import rn_pkg::*;

  // walk state within the current number
  logic       started_r;
  logic [1:0] pos_r;
  logic [1:0] idx_r;

  // output register
  logic                out_valid_r;
  logic [LETTER_W-1:0] letter_r;
  logic                last_r;
  logic                oor_r;

  logic [3:0] dig [4];
  logic [2:0] len [4];
  logic [3:0] nz;
  logic [1:0] eff_pos, next_pos;
  logic       has_next, end_dig, last, advance, emit;
  logic [LETTER_W-1:0] ch;

  // digits and their pattern lengths
  always_comb begin
    dig[0] = {2'b00, head.th};
    dig[1] = head.hu;
    dig[2] = head.te;
    dig[3] = head.on;
    for (int k = 0; k < 4; k++) begin
      len[k] = dig_len(dig[k]);
      nz[k]  = (len[k] != 3'd0);
    end
  end

  // current place: first non-empty digit at the start of a number
  always_comb begin
    if (started_r)  eff_pos = pos_r;
    else if (nz[0]) eff_pos = POS_TH;
    else if (nz[1]) eff_pos = POS_HU;
    else if (nz[2]) eff_pos = POS_TE;
    else            eff_pos = POS_ON;
  end

  // next non-empty digit after the current place
  always_comb begin
    has_next = 1'b0;
    next_pos = POS_ON;
    for (int k = 3; k >= 0; k--) begin
      if (2'(k) > eff_pos && nz[k]) begin
        has_next = 1'b1;
        next_pos = 2'(k);
      end
    end
  end

  assign end_dig = ({1'b0, idx_r} == (len[eff_pos] - 3'd1));
  assign last    = end_dig && !has_next;
  assign ch      = roman_letter(eff_pos, dig_sym(dig[eff_pos], idx_r));

  // one letter per transfer slot
  assign advance = !out_valid_r || out_ready;
  assign emit    = advance && not_empty;
  assign pop     = emit && (head.err || last);

  assign out_valid        = out_valid_r;
  assign out_letter       = letter_r;
  assign out_last_letter  = last_r;
  assign out_out_of_range = oor_r;

  // walk state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      pos_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
      if (head.err || last) begin
        started_r <= 1'b0;
        idx_r     <= '0;
      end else if (end_dig) begin
        started_r <= 1'b1;
        pos_r     <= next_pos;
        idx_r     <= '0;
      end else begin
        started_r <= 1'b1;
        pos_r     <= eff_pos;
        idx_r     <= idx_r + 2'd1;
      end
    end else if (advance) begin
      out_valid_r <= 1'b0;
    end
    if (emit) begin
      letter_r <= head.err ? '0 : ch;
      last_r   <= head.err || last;
      oor_r    <= head.err;
    end
  end

endmodule
`default_nettype wire

// File: sim/decimal_to_roman_numeral_tb.sv
`timescale 1ns / 100ps

module decimal_to_roman_numeral_tb;
  import rn_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 20;

  // one expected letter of a numeral run
  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                last_letter;
    logic                out_of_range;
  } numeral_letter_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [NUM_W-1:0]    in_number;
  logic                out_valid;
  logic                out_ready;
  logic [LETTER_W-1:0] out_letter;
  logic                out_last_letter;
  logic                out_out_of_range;

  numeral_letter_t     pending_letters[$];
  logic [LETTER_W-1:0] run_letters[$];
  bit                  idle_on;
  int                  mismatch_count;
  int                  numbers_sent;
  int                  bad_numbers_sent;
  int                  letters_checked;
  int                  cycle_count = 0;

  decimal_to_roman_numeral dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_number        (in_number),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_letter       (out_letter),
    .out_last_letter  (out_last_letter),
    .out_out_of_range (out_out_of_range)
  );

  // free-running clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d letters still pending", cycle_count,
               pending_letters.size());
      $display("decimal_to_roman_numeral: mismatch");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // letters for one decimal digit, appended to the current run
  task automatic add_digit_letters(input int digit, input logic [LETTER_W-1:0] one,
                                   input logic [LETTER_W-1:0] five,
                                   input logic [LETTER_W-1:0] ten);
    int d;
    d = digit;
    if (d == 9) begin
      run_letters = {run_letters, one};
      run_letters = {run_letters, ten};
    end else if (d == 4) begin
      run_letters = {run_letters, one};
      run_letters = {run_letters, five};
    end else begin
      if (d >= 5) begin
        run_letters = {run_letters, five};
        d -= 5;
      end
      repeat (d) run_letters = {run_letters, one};
    end
  endtask

  // expected letters of the numeral for one number
  task automatic predict_numeral(input logic [NUM_W-1:0] num);
    int              value;
    numeral_letter_t item;
    value = num;
    if (num == '0 || num > MAX_VALID) begin
      item.letter       = '0;
      item.last_letter  = 1'b1;
      item.out_of_range = 1'b1;
      pending_letters = {pending_letters, item};
    end else begin
      run_letters.delete();
      repeat (value / 1000) run_letters = {run_letters, CH_M};
      add_digit_letters((value / 100) % 10, CH_C, CH_D, CH_M);
      add_digit_letters((value / 10) % 10, CH_X, CH_L, CH_C);
      add_digit_letters(value % 10, CH_I, CH_V, CH_X);
      foreach (run_letters[i]) begin
        item.letter       = run_letters[i];
        item.last_letter  = (i == run_letters.size() - 1);
        item.out_of_range = 1'b0;
        pending_letters = {pending_letters, item};
      end
    end
  endtask

  // one number over the input channel, entered at a falling edge
  task automatic send_number(input logic [NUM_W-1:0] num);
    int gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_number <= num;
    do @(posedge clk); while (!in_ready);
    predict_numeral(num);
    numbers_sent++;
    if (num == '0 || num > MAX_VALID) bad_numbers_sent++;
    @(negedge clk);
  endtask

  // hold the input off until every letter has come out
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_letters.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly well-formed numbers, some zero or above the top
  function automatic logic [NUM_W-1:0] random_number();
    logic [NUM_W-1:0] num;
    case ($urandom_range(0, 19))
      0:       num = '0;
      1, 2:    num = NUM_W'($urandom_range(4000, 4095));
      3:       num = NUM_W'($urandom_range(3800, 3999));
      default: num = NUM_W'($urandom_range(1, 3999));
    endcase
    return num;
  endfunction

  // result side: random stall before each letter
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // compare each letter transfer with the oldest expectation
  always @(posedge clk) begin
    numeral_letter_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_letters.size() == 0) begin
        report_mismatch("letter with nothing expected", out_letter, 0);
      end else begin
        want = pending_letters.pop_front();
        letters_checked++;
        if (out_letter !== want.letter)
          report_mismatch("letter", out_letter, want.letter);
        if (out_last_letter !== want.last_letter)
          report_mismatch("last_letter", out_last_letter, want.last_letter);
        if (out_out_of_range !== want.out_of_range)
          report_mismatch("out_of_range", out_out_of_range, want.out_of_range);
      end
    end
  end

  // extremes, many digit patterns, subtractive forms and bad numbers
  task automatic test_directed();
    logic [NUM_W-1:0] cases[$];
    cases = '{12'd0, 12'd1, 12'd3999, 12'd4000, 12'd4095, 12'd3888, 12'd2000,
              12'd2222, 12'd4, 12'd9, 12'd40, 12'd90, 12'd400, 12'd900,
              12'd1944, 12'd3449, 12'd1000, 12'd5, 12'd50, 12'd500, 12'd3678,
              12'd2767, 12'd2048};
    idle_on = 1'b1;
    foreach (cases[i]) send_number(cases[i]);
    wait_for_drain();
  endtask

  // random numbers with idling on both sides
  task automatic test_random_idle(input int count);
    idle_on = 1'b1;
    repeat (count) send_number(random_number());
  endtask

  // random numbers back to back with no idling
  task automatic test_back_to_back(input int count);
    idle_on = 1'b0;
    repeat (count) send_number(random_number());
    idle_on = 1'b1;
  endtask

  // short bursts, each left to drain before the next
  task automatic test_drain_pauses(input int bursts);
    idle_on = 1'b1;
    repeat (bursts) begin
      repeat ($urandom_range(1, 6)) send_number(random_number());
      wait_for_drain();
    end
  endtask

  initial begin
    int tail_wait;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_number        = '0;
    idle_on          = 1'b1;
    mismatch_count   = 0;
    numbers_sent     = 0;
    bad_numbers_sent = 0;
    letters_checked  = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_idle(90);
    test_back_to_back(50);
    test_drain_pauses(12);
    test_random_idle(45);
    test_back_to_back(20);

    // let the last letters come out, then a quiet tail
    in_valid <= 1'b0;
    while (pending_letters.size() != 0) @(posedge clk);
    tail_wait = 0;
    while (tail_wait < TAIL_CYCLES) begin
      @(posedge clk);
      tail_wait++;
    end

    $display("sent %0d numbers (%0d out of range), checked %0d letters",
             numbers_sent, bad_numbers_sent, letters_checked);
    $display("idling, back-to-back transfers and drain pauses on both channels");
    if (mismatch_count == 0 && pending_letters.size() == 0) begin
      $display("decimal_to_roman_numeral: match");
    end else begin
      $display("%0d mismatches, %0d letters never came", mismatch_count,
               pending_letters.size());
      $display("decimal_to_roman_numeral: mismatch");
    end
    $finish;
  end

endmodule
